// ===== rtl/arcpr_pkg.sv =====
`default_nettype none

package arcpr_pkg;

   // Directory geometry
   localparam int MAX_PAGES = 64;
   localparam int NSLOT     = 2 * MAX_PAGES;
   localparam int SLOT_W    = $clog2(NSLOT);
   localparam int CNT_W     = $clog2(NSLOT + 1);
   localparam int KEY_W     = 32;
   localparam int AGE_W     = 16;
   localparam int CAP_W     = 7;
   localparam int TGT_W     = 7;
   localparam int OUT_W     = 3;
   localparam int DIV_STEP_W = $clog2(CNT_W);

   localparam logic [AGE_W-1:0] AGE_TOP = 16'hFFFF;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_RAW_W = KEY_W + 1;
   localparam int REQ_W     = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_RAW_W = OUT_W + 1 + KEY_W + 1 + TGT_W;
   localparam int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8;

   // Response field positions
   localparam int RSP_OUT_LSB   = 0;
   localparam int RSP_EVV_BIT   = OUT_W;
   localparam int RSP_KEY_LSB   = OUT_W + 1;
   localparam int RSP_DIRTY_BIT = OUT_W + 1 + KEY_W;
   localparam int RSP_TGT_LSB   = OUT_W + 2 + KEY_W;

   typedef enum logic [1:0] {
      LIST_T1 = 2'd0,
      LIST_T2 = 2'd1,
      LIST_B1 = 2'd2,
      LIST_B2 = 2'd3
   } list_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_T1_HIT = 3'd0,
      OUT_T2_HIT = 3'd1,
      OUT_B1_HIT = 3'd2,
      OUT_B2_HIT = 3'd3,
      OUT_MISS   = 3'd4
   } outcome_type;

   typedef struct packed {
      logic             dirty;
      list_type         list;
      logic [KEY_W-1:0] key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/arcpr_ram.sv =====
`default_nettype none

module arcpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/arc_page_replacement_top.sv =====
`default_nettype none
// ARC page replacement directory.
// req channel: one page access per item (key, read/write mode). rsp channel:
// one result per access (hit class, evicted page with its dirty mark, new
// recent-list target). csr_wr_en/csr_wr_data set the resident capacity; write
// it only while the block is idle. Reset sets the capacity to 64, empties all
// four lists and clears the target and the LRU clock.
// One access at a time: req_tready is high only in the idle state. An item
// walks the 128-slot directory with one compare unit, one slot per cycle:
// a hit takes one pass, plus the target divider and the ghost demotion on a
// ghost hit; a miss takes two passes. When the 16-bit LRU clock runs out,
// the stored ages are ranked again in place: 128 passes plus one copy pass.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item holds in the done state
// until the register is free.
module arc_page_replacement_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // page_key [31:0], mode [32], zero [39:33]
   input  wire logic [arcpr_pkg::REQ_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // outcome [2:0], evict_valid [3], evict_key [35:4], evict_dirty [36],
   // recent_target [43:37], zero [47:44]
   output logic      [arcpr_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                        csr_wr_en,
   input  wire logic [arcpr_pkg::CAP_W-1:0] csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_ADAPT, S_EVICT, S_DEM_RD, S_DEM_WR,
      S_HIT_MOVE, S_SCAN2, S_ALLOC, S_STAMP, S_RN_RD, S_RN_LAT, S_RN_SCAN,
      S_RN_WR, S_RN_COPY, S_DONE
   } state_type;

   localparam int SW = arcpr_pkg::SLOT_W;
   localparam int CW = arcpr_pkg::CNT_W;
   localparam int AW = arcpr_pkg::AGE_W;
   localparam int KW = arcpr_pkg::KEY_W;
   localparam int TW = arcpr_pkg::TGT_W;

   state_type                    state_ff, state_in, stamp_ret_ff, stamp_ret_in;
   logic [arcpr_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [KW-1:0]                key_ff, key_in;
   logic                         mode_ff, mode_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         proc_v_ff, proc_v_in;
   logic [SW-1:0]                proc_idx_ff, proc_idx_in;
   logic                         scan2_ff, scan2_in;
   logic                         match_found_ff, match_found_in;
   logic [SW-1:0]                match_idx_ff, match_idx_in;
   arcpr_pkg::entry_type         match_ent_ff, match_ent_in;
   logic                         free_found_ff, free_found_in;
   logic [SW-1:0]                free_idx_ff, free_idx_in;
   logic                         tail_found_ff [4];
   logic                         tail_found_in [4];
   logic [SW-1:0]                tail_idx_ff [4];
   logic [SW-1:0]                tail_idx_in [4];
   logic [AW-1:0]                tail_age_ff [4];
   logic [AW-1:0]                tail_age_in [4];
   logic [arcpr_pkg::NSLOT-1:0]  valid_ff, valid_in;
   logic [CW-1:0]                lcnt_ff [4];
   logic [CW-1:0]                lcnt_in [4];
   logic [TW-1:0]                target_ff, target_in;
   logic [AW-1:0]                clock_ff, clock_in;
   logic                         is_hit_ff, is_hit_in;
   arcpr_pkg::outcome_type       outcome_ff, outcome_in;
   logic                         in_b2_ff, in_b2_in;
   logic [SW-1:0]                victim_ff, victim_in;
   arcpr_pkg::list_type          ghost_ff, ghost_in;
   logic [CW-1:0]                div_num_ff, div_num_in;
   logic [CW-1:0]                div_den_ff, div_den_in;
   logic [CW-1:0]                div_rem_ff, div_rem_in;
   logic [CW-1:0]                div_q_ff, div_q_in;
   logic [arcpr_pkg::DIV_STEP_W-1:0] div_step_ff, div_step_in;
   logic                         ev_valid_ff, ev_valid_in;
   logic [KW-1:0]                ev_key_ff, ev_key_in;
   logic                         ev_dirty_ff, ev_dirty_in;
   logic [SW-1:0]                stamp_slot_ff, stamp_slot_in;
   logic [CW-1:0]                rn_i_ff, rn_i_in;
   logic [AW-1:0]                age_i_ff, age_i_in;
   logic [SW-1:0]                rank_ff, rank_in;
   logic [CW-1:0]                nvalid_ff, nvalid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [arcpr_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // Memory ports
   logic                         ent_we;
   logic [SW-1:0]                ent_waddr, ent_raddr;
   arcpr_pkg::entry_type         ent_wdata, ent_rd;
   logic [arcpr_pkg::ENTRY_W-1:0] ent_rd_raw;
   logic                         age_we;
   logic [SW-1:0]                age_waddr, age_raddr;
   logic [AW-1:0]                age_wdata, age_rd;
   logic                         rank_we;
   logic [SW-1:0]                rank_waddr;
   logic [SW-1:0]                rank_wdata, rank_rd;

   logic [arcpr_pkg::CAP_W-1:0]  cap_eff;

   assign ent_rd = arcpr_pkg::entry_type'(ent_rd_raw);

   arcpr_ram #(.WIDTH(arcpr_pkg::ENTRY_W), .DEPTH(arcpr_pkg::NSLOT)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rd_raw)
   );

   arcpr_ram #(.WIDTH(AW), .DEPTH(arcpr_pkg::NSLOT)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_addr (age_raddr),
      .rd_data (age_rd)
   );

   arcpr_ram #(.WIDTH(SW), .DEPTH(arcpr_pkg::NSLOT)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_addr (cnt_ff[SW-1:0]),
      .rd_data (rank_rd)
   );

   // Clamp the capacity to 1..MAX_PAGES
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = arcpr_pkg::CAP_W'(1);
      end else if (cap_ff > arcpr_pkg::CAP_W'(arcpr_pkg::MAX_PAGES)) begin
         cap_eff = arcpr_pkg::CAP_W'(arcpr_pkg::MAX_PAGES);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // Read addresses follow the sequencer
   always_comb begin
      ent_raddr = (state_ff == S_DEM_RD) ? victim_ff : cnt_ff[SW-1:0];
      age_raddr = (state_ff == S_RN_RD) ? rn_i_ff[SW-1:0] : cnt_ff[SW-1:0];
   end

   // Sequencer next state
   always_comb begin
      logic                 v;
      logic [CW:0]          t1b1;
      logic [CW:0]          total;
      logic [CW:0]          cap_x;
      logic [CW:0]          trial;
      logic [CW-1:0]        dq;
      logic [TW+CW:0]       sum;
      logic                 from_recent;
      logic [SW-1:0]        aidx;
      arcpr_pkg::list_type  dlist;
      logic                 dfound;

      state_in       = state_ff;
      stamp_ret_in   = stamp_ret_ff;
      cap_in         = cap_ff;
      key_in         = key_ff;
      mode_in        = mode_ff;
      cnt_in         = cnt_ff;
      proc_v_in      = proc_v_ff;
      proc_idx_in    = proc_idx_ff;
      scan2_in       = scan2_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_ent_in   = match_ent_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      tail_found_in  = tail_found_ff;
      tail_idx_in    = tail_idx_ff;
      tail_age_in    = tail_age_ff;
      valid_in       = valid_ff;
      lcnt_in        = lcnt_ff;
      target_in      = target_ff;
      clock_in       = clock_ff;
      is_hit_in      = is_hit_ff;
      outcome_in     = outcome_ff;
      in_b2_in       = in_b2_ff;
      victim_in      = victim_ff;
      ghost_in       = ghost_ff;
      div_num_in     = div_num_ff;
      div_den_in     = div_den_ff;
      div_rem_in     = div_rem_ff;
      div_q_in       = div_q_ff;
      div_step_in    = div_step_ff;
      ev_valid_in    = ev_valid_ff;
      ev_key_in      = ev_key_ff;
      ev_dirty_in    = ev_dirty_ff;
      stamp_slot_in  = stamp_slot_ff;
      rn_i_in        = rn_i_ff;
      age_i_in       = age_i_ff;
      rank_in        = rank_ff;
      nvalid_in      = nvalid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      ent_we     = 1'b0;
      ent_waddr  = victim_ff;
      ent_wdata  = match_ent_ff;
      age_we     = 1'b0;
      age_waddr  = stamp_slot_ff;
      age_wdata  = clock_ff;
      rank_we    = 1'b0;
      rank_waddr = rn_i_ff[SW-1:0];
      rank_wdata = rank_ff;

      v           = valid_ff[proc_idx_ff];
      t1b1        = '0;
      total       = '0;
      cap_x       = (CW+1)'(cap_eff);
      trial       = '0;
      dq          = '0;
      sum         = '0;
      from_recent = 1'b0;
      aidx        = '0;
      dlist       = arcpr_pkg::LIST_T1;
      dfound      = 1'b0;

      // Drop a taken result
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in         = req_tdata[KW-1:0];
               mode_in        = req_tdata[KW];
               ev_valid_in    = 1'b0;
               ev_key_in      = '0;
               ev_dirty_in    = 1'b0;
               scan2_in       = 1'b0;
               cnt_in         = '0;
               proc_v_in      = 1'b0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               for (int k = 0; k < 4; k++) begin
                  tail_found_in[k] = 1'b0;
               end
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // Advance the read pointer one slot a cycle
            if (!cnt_ff[CW-1]) begin
               proc_v_in   = 1'b1;
               proc_idx_in = cnt_ff[SW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               proc_v_in = 1'b0;
               if (!proc_v_ff) begin
                  state_in = scan2_ff ? S_ALLOC : S_DECIDE;
               end
            end
            // Compare the slot read last cycle
            if (proc_v_ff) begin
               if (v && ent_rd.key == key_ff && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = proc_idx_ff;
                  match_ent_in   = ent_rd;
               end
               if (!v && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx_ff;
               end
               for (int k = 0; k < 4; k++) begin
                  if (v && ent_rd.list == arcpr_pkg::list_type'(k) &&
                      (!tail_found_ff[k] || age_rd < tail_age_ff[k])) begin
                     tail_found_in[k] = 1'b1;
                     tail_idx_in[k]   = proc_idx_ff;
                     tail_age_in[k]   = age_rd;
                  end
               end
            end
         end

         S_DECIDE: begin
            div_rem_in  = '0;
            div_q_in    = '0;
            div_step_in = '0;
            if (match_found_ff) begin
               is_hit_in  = 1'b1;
               outcome_in = arcpr_pkg::outcome_type'({1'b0, match_ent_ff.list});
               unique case (match_ent_ff.list)
                  arcpr_pkg::LIST_B1: begin
                     in_b2_in   = 1'b0;
                     div_num_in = lcnt_ff[arcpr_pkg::LIST_B2];
                     div_den_in = (lcnt_ff[arcpr_pkg::LIST_B1] == '0) ? CW'(1)
                                  : lcnt_ff[arcpr_pkg::LIST_B1];
                     state_in   = S_DIV;
                  end
                  arcpr_pkg::LIST_B2: begin
                     in_b2_in   = 1'b1;
                     div_num_in = lcnt_ff[arcpr_pkg::LIST_B1];
                     div_den_in = (lcnt_ff[arcpr_pkg::LIST_B2] == '0) ? CW'(1)
                                  : lcnt_ff[arcpr_pkg::LIST_B2];
                     state_in   = S_DIV;
                  end
                  default: begin
                     state_in = S_HIT_MOVE;
                  end
               endcase
            end else begin
               is_hit_in  = 1'b0;
               outcome_in = arcpr_pkg::OUT_MISS;
               in_b2_in   = 1'b0;
               t1b1  = (CW+1)'(lcnt_ff[arcpr_pkg::LIST_T1]) +
                       (CW+1)'(lcnt_ff[arcpr_pkg::LIST_B1]);
               total = t1b1 + (CW+1)'(lcnt_ff[arcpr_pkg::LIST_T2]) +
                       (CW+1)'(lcnt_ff[arcpr_pkg::LIST_B2]);
               priority if (t1b1 == cap_x) begin
                  if ((CW+1)'(lcnt_ff[arcpr_pkg::LIST_T1]) < cap_x) begin
                     // Drop the oldest recent ghost, then evict
                     if (tail_found_ff[arcpr_pkg::LIST_B1]) begin
                        valid_in[tail_idx_ff[arcpr_pkg::LIST_B1]] = 1'b0;
                        lcnt_in[arcpr_pkg::LIST_B1] =
                           lcnt_ff[arcpr_pkg::LIST_B1] - CW'(1);
                     end
                     state_in = S_EVICT;
                  end else begin
                     // Recent list alone is full: demote its oldest page
                     victim_in = tail_idx_ff[arcpr_pkg::LIST_T1];
                     ghost_in  = arcpr_pkg::LIST_B1;
                     state_in  = S_DEM_RD;
                  end
               end else if (total >= cap_x) begin
                  if (total >= (cap_x << 1) && tail_found_ff[arcpr_pkg::LIST_B2]) begin
                     valid_in[tail_idx_ff[arcpr_pkg::LIST_B2]] = 1'b0;
                     lcnt_in[arcpr_pkg::LIST_B2] =
                        lcnt_ff[arcpr_pkg::LIST_B2] - CW'(1);
                  end
                  state_in = S_EVICT;
               end else begin
                  state_in = S_SCAN2;
               end
            end
         end

         S_DIV: begin
            // One restoring step per cycle
            trial = {div_rem_ff, div_num_ff[CW-1]};
            div_num_in = div_num_ff << 1;
            if (trial >= (CW+1)'(div_den_ff)) begin
               div_rem_in = CW'(trial - (CW+1)'(div_den_ff));
               div_q_in   = {div_q_ff[CW-2:0], 1'b1};
            end else begin
               div_rem_in = trial[CW-1:0];
               div_q_in   = {div_q_ff[CW-2:0], 1'b0};
            end
            div_step_in = div_step_ff + 1'b1;
            if (div_step_ff == arcpr_pkg::DIV_STEP_W'(CW - 1)) begin
               state_in = S_ADAPT;
            end
         end

         S_ADAPT: begin
            dq = (div_q_ff == '0) ? CW'(1) : div_q_ff;
            if (!in_b2_ff) begin
               sum = (TW+CW+1)'(target_ff) + (TW+CW+1)'(dq);
               if (sum > (TW+CW+1)'(cap_eff)) begin
                  target_in = TW'(cap_eff);
               end else begin
                  target_in = sum[TW-1:0];
               end
            end else begin
               if ((CW+1)'(target_ff) > (CW+1)'(dq)) begin
                  target_in = target_ff - dq[TW-1:0];
               end else begin
                  target_in = '0;
               end
            end
            state_in = S_EVICT;
         end

         S_EVICT: begin
            from_recent = (lcnt_ff[arcpr_pkg::LIST_T1] != '0) &&
               ((in_b2_ff && lcnt_ff[arcpr_pkg::LIST_T1] == CW'(target_ff)) ||
                lcnt_ff[arcpr_pkg::LIST_T1] > CW'(target_ff));
            priority if (from_recent) begin
               victim_in = tail_idx_ff[arcpr_pkg::LIST_T1];
               ghost_in  = arcpr_pkg::LIST_B1;
               state_in  = S_DEM_RD;
            end else if (lcnt_ff[arcpr_pkg::LIST_T2] != '0) begin
               victim_in = tail_idx_ff[arcpr_pkg::LIST_T2];
               ghost_in  = arcpr_pkg::LIST_B2;
               state_in  = S_DEM_RD;
            end else begin
               state_in = is_hit_ff ? S_HIT_MOVE : S_SCAN2;
            end
         end

         S_DEM_RD: begin
            state_in = S_DEM_WR;
         end

         S_DEM_WR: begin
            // Report the evicted page, move it to its ghost list
            ev_valid_in = 1'b1;
            ev_key_in   = ent_rd.key;
            ev_dirty_in = ent_rd.dirty;
            ent_we      = 1'b1;
            ent_waddr   = victim_ff;
            ent_wdata   = '{dirty: ent_rd.dirty, list: ghost_ff, key: ent_rd.key};
            lcnt_in[ent_rd.list] = lcnt_in[ent_rd.list] - CW'(1);
            lcnt_in[ghost_ff]    = lcnt_in[ghost_ff] + CW'(1);
            stamp_slot_in = victim_ff;
            stamp_ret_in  = is_hit_ff ? S_HIT_MOVE : S_SCAN2;
            state_in      = S_STAMP;
         end

         S_HIT_MOVE: begin
            ent_we    = 1'b1;
            ent_waddr = match_idx_ff;
            ent_wdata = '{dirty: match_ent_ff.dirty | mode_ff,
                          list: arcpr_pkg::LIST_T2, key: key_ff};
            lcnt_in[match_ent_ff.list] = lcnt_in[match_ent_ff.list] - CW'(1);
            lcnt_in[arcpr_pkg::LIST_T2] = lcnt_in[arcpr_pkg::LIST_T2] + CW'(1);
            stamp_slot_in = match_idx_ff;
            stamp_ret_in  = S_DONE;
            state_in      = S_STAMP;
         end

         S_SCAN2: begin
            scan2_in       = 1'b1;
            cnt_in         = '0;
            proc_v_in      = 1'b0;
            match_found_in = 1'b0;
            free_found_in  = 1'b0;
            for (int k = 0; k < 4; k++) begin
               tail_found_in[k] = 1'b0;
            end
            state_in = S_SCAN;
         end

         S_ALLOC: begin
            // Free slot first, else drop the oldest of B1, B2, T1, T2
            if (free_found_ff) begin
               aidx = free_idx_ff;
            end else begin
               priority if (tail_found_ff[arcpr_pkg::LIST_B1]) begin
                  aidx = tail_idx_ff[arcpr_pkg::LIST_B1];
                  dlist = arcpr_pkg::LIST_B1;
                  dfound = 1'b1;
               end else if (tail_found_ff[arcpr_pkg::LIST_B2]) begin
                  aidx = tail_idx_ff[arcpr_pkg::LIST_B2];
                  dlist = arcpr_pkg::LIST_B2;
                  dfound = 1'b1;
               end else if (tail_found_ff[arcpr_pkg::LIST_T1]) begin
                  aidx = tail_idx_ff[arcpr_pkg::LIST_T1];
                  dlist = arcpr_pkg::LIST_T1;
                  dfound = 1'b1;
               end else if (tail_found_ff[arcpr_pkg::LIST_T2]) begin
                  aidx = tail_idx_ff[arcpr_pkg::LIST_T2];
                  dlist = arcpr_pkg::LIST_T2;
                  dfound = 1'b1;
               end else begin
                  aidx = '0;
               end
            end
            if (dfound) begin
               lcnt_in[dlist] = lcnt_in[dlist] - CW'(1);
            end
            lcnt_in[arcpr_pkg::LIST_T1] = lcnt_in[arcpr_pkg::LIST_T1] + CW'(1);
            valid_in[aidx] = 1'b1;
            ent_we    = 1'b1;
            ent_waddr = aidx;
            ent_wdata = '{dirty: mode_ff, list: arcpr_pkg::LIST_T1, key: key_ff};
            stamp_slot_in = aidx;
            stamp_ret_in  = S_DONE;
            state_in      = S_STAMP;
         end

         S_STAMP: begin
            if (clock_ff == arcpr_pkg::AGE_TOP) begin
               rn_i_in  = '0;
               state_in = S_RN_RD;
            end else begin
               age_we    = 1'b1;
               age_waddr = stamp_slot_ff;
               age_wdata = clock_ff;
               clock_in  = clock_ff + AW'(1);
               state_in  = stamp_ret_ff;
            end
         end

         S_RN_RD: begin
            state_in = S_RN_LAT;
         end

         S_RN_LAT: begin
            age_i_in  = age_rd;
            cnt_in    = '0;
            proc_v_in = 1'b0;
            rank_in   = '0;
            state_in  = S_RN_SCAN;
         end

         S_RN_SCAN: begin
            // Count older valid slots, leaving out the slot being stamped
            if (!cnt_ff[CW-1]) begin
               proc_v_in   = 1'b1;
               proc_idx_in = cnt_ff[SW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               proc_v_in = 1'b0;
               if (!proc_v_ff) begin
                  state_in = S_RN_WR;
               end
            end
            if (proc_v_ff && v && proc_idx_ff != stamp_slot_ff && age_rd < age_i_ff) begin
               rank_in = rank_ff + SW'(1);
            end
         end

         S_RN_WR: begin
            rank_we    = 1'b1;
            rank_waddr = rn_i_ff[SW-1:0];
            rank_wdata = rank_ff;
            rn_i_in    = rn_i_ff + CW'(1);
            if (rn_i_ff[SW-1:0] == SW'(arcpr_pkg::NSLOT - 1)) begin
               cnt_in    = '0;
               proc_v_in = 1'b0;
               nvalid_in = '0;
               state_in  = S_RN_COPY;
            end else begin
               state_in = S_RN_RD;
            end
         end

         S_RN_COPY: begin
            // Copy the ranks back as ages
            if (!cnt_ff[CW-1]) begin
               proc_v_in   = 1'b1;
               proc_idx_in = cnt_ff[SW-1:0];
               cnt_in      = cnt_ff + CW'(1);
            end else begin
               proc_v_in = 1'b0;
               if (!proc_v_ff) begin
                  clock_in = AW'(nvalid_ff);
                  state_in = S_STAMP;
               end
            end
            if (proc_v_ff && v) begin
               nvalid_in = nvalid_ff + CW'(1);
               if (proc_idx_ff != stamp_slot_ff) begin
                  age_we    = 1'b1;
                  age_waddr = proc_idx_ff;
                  age_wdata = AW'(rank_rd);
               end
            end
         end

         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[arcpr_pkg::RSP_OUT_LSB +: arcpr_pkg::OUT_W] = outcome_ff;
               rsp_data_in[arcpr_pkg::RSP_EVV_BIT]               = ev_valid_ff;
               rsp_data_in[arcpr_pkg::RSP_KEY_LSB +: KW]         = ev_key_ff;
               rsp_data_in[arcpr_pkg::RSP_DIRTY_BIT]             = ev_dirty_ff;
               rsp_data_in[arcpr_pkg::RSP_TGT_LSB +: TW]         = target_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= arcpr_pkg::CAP_W'(arcpr_pkg::MAX_PAGES);
         valid_ff     <= '0;
         for (int k = 0; k < 4; k++) begin
            lcnt_ff[k] <= '0;
         end
         target_ff    <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         proc_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         lcnt_ff      <= lcnt_in;
         target_ff    <= target_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
         proc_v_ff    <= proc_v_in;
      end
      stamp_ret_ff   <= stamp_ret_in;
      key_ff         <= key_in;
      mode_ff        <= mode_in;
      cnt_ff         <= cnt_in;
      proc_idx_ff    <= proc_idx_in;
      scan2_ff       <= scan2_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_ent_ff   <= match_ent_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      tail_found_ff  <= tail_found_in;
      tail_idx_ff    <= tail_idx_in;
      tail_age_ff    <= tail_age_in;
      is_hit_ff      <= is_hit_in;
      outcome_ff     <= outcome_in;
      in_b2_ff       <= in_b2_in;
      victim_ff      <= victim_in;
      ghost_ff       <= ghost_in;
      div_num_ff     <= div_num_in;
      div_den_ff     <= div_den_in;
      div_rem_ff     <= div_rem_in;
      div_q_ff       <= div_q_in;
      div_step_ff    <= div_step_in;
      ev_valid_ff    <= ev_valid_in;
      ev_key_ff      <= ev_key_in;
      ev_dirty_ff    <= ev_dirty_in;
      stamp_slot_ff  <= stamp_slot_in;
      rn_i_ff        <= rn_i_in;
      age_i_ff       <= age_i_in;
      rank_ff        <= rank_in;
      nvalid_ff      <= nvalid_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/arcpr_checker.sv =====
`default_nettype none

module arcpr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [arcpr_pkg::RSP_W-1:0] rsp_tdata
);

   logic                           evv;
   logic                           dirty;
   logic [arcpr_pkg::KEY_W-1:0]    ekey;
   logic [arcpr_pkg::OUT_W-1:0]    oc;
   logic [arcpr_pkg::TGT_W-1:0]    tgt;

   assign evv   = rsp_tdata[arcpr_pkg::RSP_EVV_BIT];
   assign dirty = rsp_tdata[arcpr_pkg::RSP_DIRTY_BIT];
   assign ekey  = rsp_tdata[arcpr_pkg::RSP_KEY_LSB +: arcpr_pkg::KEY_W];
   assign oc    = rsp_tdata[arcpr_pkg::RSP_OUT_LSB +: arcpr_pkg::OUT_W];
   assign tgt   = rsp_tdata[arcpr_pkg::RSP_TGT_LSB +: arcpr_pkg::TGT_W];

   // A stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // No eviction means zero key and clean mark
   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !evv |-> ekey == '0 && !dirty)
      else $error("eviction fields set without eviction");

   // Resident hits never evict
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (oc == arcpr_pkg::OUT_T1_HIT || oc == arcpr_pkg::OUT_T2_HIT)
      |-> !evv)
      else $error("eviction on a resident hit");

   // Target stays within the page limit, outcome within the known codes
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> tgt <= arcpr_pkg::TGT_W'(arcpr_pkg::MAX_PAGES) &&
      oc <= arcpr_pkg::OUT_MISS)
      else $error("target or outcome out of range");

   // Reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block busy right after reset");

endmodule

bind arc_page_replacement_top arcpr_checker u_arcpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/sv/arc_page_replacement_top_tb.sv =====
`default_nettype none

module arc_page_replacement_top_tb;
   import arcpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;

   typedef struct {
      outcome_type      outcome;
      logic             evict_valid;
      logic [KEY_W-1:0] evict_key;
      logic             evict_dirty;
      logic [TGT_W-1:0] recent_target;
   } access_result;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en = 1'b0;
   logic [CAP_W-1:0]     csr_wr_data = '0;

   // Shadow directory
   logic [KEY_W-1:0] dir_key[NSLOT];
   bit               dir_valid[NSLOT];
   list_type         dir_list[NSLOT];
   int unsigned      dir_age[NSLOT];
   bit               dir_dirty[NSLOT];
   int unsigned      list_len[4];
   int unsigned      target_pages;
   int unsigned      lru_clock;
   int unsigned      capacity;
   access_result     evicted;

   access_result     pending_results[$];
   int               error_count = 0;
   bit               steady = 1'b0;
   int               quiet_cycles = 0;
   int               stall_count = 0;

   arc_page_replacement_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ---------------- shadow ARC ----------------
   function automatic int unsigned usable_pages();
      if (capacity == 0) return 1;
      if (capacity > MAX_PAGES) return MAX_PAGES;
      return capacity;
   endfunction

   function automatic int unsigned take_stamp();
      int unsigned rank[NSLOT];
      int unsigned live;
      live = 0;
      if (lru_clock >= AGE_TOP) begin
         for (int i = 0; i < NSLOT; i++) begin
            rank[i] = 0;
            if (dir_valid[i]) begin
               for (int j = 0; j < NSLOT; j++)
                  if (dir_valid[j] && dir_age[j] < dir_age[i]) rank[i]++;
               live++;
            end
         end
         for (int i = 0; i < NSLOT; i++)
            if (dir_valid[i]) dir_age[i] = rank[i];
         lru_clock = live;
      end
      lru_clock++;
      return lru_clock - 1;
   endfunction

   function automatic int lru_slot(list_type which);
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (dir_valid[i] && dir_list[i] == which &&
             (best < 0 || dir_age[i] < dir_age[best])) best = i;
      return best;
   endfunction

   function automatic void to_front(int i, list_type which);
      list_len[dir_list[i]]--;
      dir_list[i] = which;
      list_len[which]++;
      dir_age[i] = take_stamp();
   endfunction

   function automatic void forget_slot(int i);
      list_len[dir_list[i]]--;
      dir_valid[i] = 0;
      dir_dirty[i] = 0;
      dir_list[i]  = LIST_T1;
   endfunction

   function automatic void demote_slot(int i, list_type ghost);
      evicted.evict_valid = 1'b1;
      evicted.evict_key   = dir_key[i];
      evicted.evict_dirty = dir_dirty[i];
      to_front(i, ghost);
   endfunction

   function automatic void replace_one(bit in_b2);
      int unsigned t1;
      t1 = list_len[LIST_T1];
      if (t1 != 0 && ((in_b2 && t1 == target_pages) || t1 > target_pages))
         demote_slot(lru_slot(LIST_T1), LIST_B1);
      else if (list_len[LIST_T2] != 0)
         demote_slot(lru_slot(LIST_T2), LIST_B2);
   endfunction

   function automatic void adapt_target(bit recent_ghost);
      int unsigned b1, b2, d;
      b1 = list_len[LIST_B1];
      b2 = list_len[LIST_B2];
      if (recent_ghost) begin
         d = b2 / (b1 != 0 ? b1 : 1);
         if (d == 0) d = 1;
         target_pages = (target_pages + d > usable_pages()) ? usable_pages()
                                                             : target_pages + d;
      end else begin
         d = b1 / (b2 != 0 ? b2 : 1);
         if (d == 0) d = 1;
         target_pages = (target_pages > d) ? target_pages - d : 0;
      end
   endfunction

   function automatic int claim_slot();
      list_type order[4];
      int t;
      order = '{LIST_B1, LIST_B2, LIST_T1, LIST_T2};
      for (int i = 0; i < NSLOT; i++)
         if (!dir_valid[i]) return i;
      for (int k = 0; k < 4; k++) begin
         t = lru_slot(order[k]);
         if (t >= 0) begin
            forget_slot(t);
            return t;
         end
      end
      return 0;
   endfunction

   function automatic void clear_directory();
      for (int i = 0; i < NSLOT; i++) begin
         dir_valid[i] = 0;
         dir_dirty[i] = 0;
         dir_list[i]  = LIST_T1;
         dir_age[i]   = 0;
         dir_key[i]   = '0;
      end
      list_len = '{0, 0, 0, 0};
      target_pages = 0;
      lru_clock = 0;
      capacity = MAX_PAGES;
   endfunction

   function automatic access_result access_page(logic [KEY_W-1:0] key, bit wr);
      int i, g;
      int unsigned cap, t1, b1, total;
      list_type l;
      i = -1;
      evicted = '{OUT_MISS, 1'b0, '0, 1'b0, '0};
      for (int s = 0; s < NSLOT; s++)
         if (i < 0 && dir_valid[s] && dir_key[s] == key) i = s;
      if (i >= 0) begin
         l = dir_list[i];
         evicted.outcome = outcome_type'(l);
         if (l == LIST_B1 || l == LIST_B2) begin
            adapt_target(l == LIST_B1);
            replace_one(l == LIST_B2);
         end
         to_front(i, LIST_T2);
         if (wr) dir_dirty[i] = 1;
      end else begin
         cap = usable_pages();
         t1 = list_len[LIST_T1];
         b1 = list_len[LIST_B1];
         total = t1 + b1 + list_len[LIST_T2] + list_len[LIST_B2];
         if (t1 + b1 == cap) begin
            if (t1 < cap) begin
               g = lru_slot(LIST_B1);
               if (g >= 0) forget_slot(g);
               replace_one(1'b0);
            end else begin
               demote_slot(lru_slot(LIST_T1), LIST_B1);
            end
         end else if (total >= cap) begin
            if (total >= 2 * cap) begin
               g = lru_slot(LIST_B2);
               if (g >= 0) forget_slot(g);
            end
            replace_one(1'b0);
         end
         i = claim_slot();
         dir_key[i]   = key;
         dir_valid[i] = 1;
         dir_dirty[i] = wr;
         dir_list[i]  = LIST_T1;
         list_len[LIST_T1]++;
         to_front(i, LIST_T1);
      end
      evicted.recent_target = target_pages[TGT_W-1:0];
      return evicted;
   endfunction

   // ---------------- driving ----------------
   // Send one access and hold it until the block takes it
   task automatic send_access(logic [KEY_W-1:0] key, bit wr);
      if (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - KEY_W - 1){1'b0}}, wr, key};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pending_results.push_back(access_page(key, wr));
   endtask

   // Drain outstanding results, then write the capacity register
   task automatic set_capacity(logic [CAP_W-1:0] pages);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= pages;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity = pages;
   endtask

   // Reuse a small pool of keys so hits and ghost hits happen often
   task automatic run_random(int items, int unsigned pool_size);
      logic [KEY_W-1:0] pool[];
      logic [KEY_W-1:0] key;
      pool = new[pool_size];
      foreach (pool[k]) pool[k] = $urandom;
      pool[0] = '0;
      pool[pool_size - 1] = '1;
      for (int n = 0; n < items; n++) begin
         steady = (n >= items / 3 && n < items / 2);
         if ($urandom_range(99) < 8) key = $urandom;
         else key = pool[$urandom_range(pool_size - 1)];
         send_access(key, $urandom_range(1));
      end
      steady = 1'b0;
   endtask

   task automatic test_extremes();
      send_access('0, 1'b0);
      send_access('1, 1'b1);
      send_access('0, 1'b1);
      send_access('0, 1'b0);
      send_access('1, 1'b0);
      send_access(32'hA5A5_5A5A, 1'b0);
   endtask

   // Tiny cache: full recent list, ghost hits both ways, dirty evictions
   task automatic test_tiny_cache();
      set_capacity(7'd2);
      send_access(32'h11, 1'b1);
      send_access(32'h22, 1'b0);
      send_access(32'h33, 1'b0);
      send_access(32'h11, 1'b0);
      send_access(32'h22, 1'b1);
      send_access(32'h22, 1'b0);
      send_access(32'h44, 1'b0);
      send_access(32'h55, 1'b0);
      send_access(32'h22, 1'b0);
      send_access(32'h33, 1'b1);
      send_access(32'h66, 1'b0);
      send_access(32'h77, 1'b0);
      send_access(32'h11, 1'b0);
      set_capacity(7'd0);
      send_access(32'h88, 1'b1);
      send_access(32'h99, 1'b0);
      send_access(32'h88, 1'b0);
   endtask

   task automatic test_random_capacities();
      int unsigned caps[8];
      caps = '{1, 64, 3, 127, 9, 0, 33, 64};
      foreach (caps[c]) begin
         set_capacity(caps[c][CAP_W-1:0]);
         run_random(110, (caps[c] == 0 ? 1 : (caps[c] > 64 ? 64 : caps[c])) * 3 + 3);
      end
      set_capacity(CAP_W'($urandom_range(1, 64)));
      run_random(70, 40);
   endtask

   // ---------------- checking ----------------
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      access_result want;
      logic [RSP_W-1:0] got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got[RSP_OUT_LSB +: OUT_W] !== want.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                        got[RSP_OUT_LSB +: OUT_W]);
               error_count++;
            end
            if (got[RSP_EVV_BIT] !== want.evict_valid) begin
               $display("%0t: evict_valid expected %0b actual %0b", $time,
                        want.evict_valid, got[RSP_EVV_BIT]);
               error_count++;
            end
            if (got[RSP_KEY_LSB +: KEY_W] !== want.evict_key) begin
               $display("%0t: evict_key expected %h actual %h", $time, want.evict_key,
                        got[RSP_KEY_LSB +: KEY_W]);
               error_count++;
            end
            if (got[RSP_DIRTY_BIT] !== want.evict_dirty) begin
               $display("%0t: evict_dirty expected %0b actual %0b", $time,
                        want.evict_dirty, got[RSP_DIRTY_BIT]);
               error_count++;
            end
            if (got[RSP_TGT_LSB +: TGT_W] !== want.recent_target) begin
               $display("%0t: recent_target expected %0d actual %0d", $time,
                        want.recent_target, got[RSP_TGT_LSB +: TGT_W]);
               error_count++;
            end
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_count <= 0;
      else if (req_tvalid || pending_results.size() != 0) begin
         stall_count <= stall_count + 1;
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      clear_directory();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_tiny_cache();
      test_random_capacities();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
